[sv/sfp_pkg.sv]
package sfp_pkg;

   // configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SINGLE_START = 2'd0;
   localparam csr_index_type CSR_SINGLE_END   = 2'd1;

   localparam logic [15:0] RESET_SINGLE_START = 16'd6554;
   localparam logic [15:0] RESET_SINGLE_END   = 16'd58982;

   // queue between front and back
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = 2;
   localparam int Q_CNT_BITS = 3;

   // fixed-point constants
   localparam logic [16:0] Q16_ONE   = 17'h10000;
   localparam logic [13:0] SKEW_COEF = 14'd11141;
   localparam logic [30:0] Q30_ONE   = 31'h40000000;

   // sin(pi/2*u) Taylor coefficients, Q1.30
   localparam logic [30:0] SIN_C1 = 31'd1686629713;
   localparam logic [30:0] SIN_C3 = 31'd693598668;
   localparam logic [30:0] SIN_C5 = 31'd85569309;
   localparam logic [30:0] SIN_C7 = 31'd5026995;
   localparam logic [30:0] SIN_C9 = 31'd172273;

   // one step of the power pipeline (bit search for s^0.8)
   typedef struct packed {
      logic [16:0] s16;
      logic [15:0] sup;
      logic [31:0] x2;
      logic [44:0] m;
      logic [79:0] tgt;
      logic [15:0] y;
      logic [31:0] c2;
      logic [63:0] c4;
      logic [47:0] phi;
      logic [47:0] plo;
   } pw_type;

endpackage

[sv/swing_foot_phase_profile_top.sv]
// A result reaches the rsp_ ports through the divider, the queue, the s^0.8 bit search,
// the sine lanes and the output register. Throughput: one item per cycle unless a full
// queue or an unpopped result stalls it; the divider (one quotient bit per stage), the
// s^0.8 bit search (four stages per result bit) and the sine lanes are all pipelined.
// A 4-entry queue parts the divider front from the shaping back.
// Reset (synchronous, active high) empties every stage and the queue and loads
// single_start = 6554 and single_end = 58982.
module swing_foot_phase_profile_top #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  sfp_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [15:0]            req_gait_phase,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [15:0]            rsp_support_fraction,
   output logic [15:0]            rsp_forward_fraction,
   output logic [15:0]            rsp_lift_fraction
);
   import sfp_pkg::*;

   logic                   q_push, q_full, q_empty, q_pop;
   logic [FRACTION_BITS:0] q_wdata, q_rdata;

   sfp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_gait_phase (req_gait_phase),
      .q_push         (q_push),
      .q_full         (q_full),
      .q_data         (q_wdata)
   );

   sfp_queue #(.WIDTH(FRACTION_BITS + 1)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   sfp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (!q_empty),
      .in_s                 (q_rdata),
      .in_take              (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_support_fraction (rsp_support_fraction),
      .rsp_forward_fraction (rsp_forward_fraction),
      .rsp_lift_fraction    (rsp_lift_fraction)
   );

endmodule

[sv/sfp_front.sv]
module sfp_front #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  sfp_pkg::csr_index_type     csr_index,
   input  logic [15:0]                csr_wdata,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [15:0]                req_gait_phase,
   output logic                       q_push,
   input  logic                       q_full,
   output logic [FRACTION_BITS:0]     q_data
);
   import sfp_pkg::*;

   localparam int F = FRACTION_BITS;

   logic [15:0]  single_start_ff;
   logic [15:0]  single_end_ff;

   logic         vld_ff [0:F];
   logic [15:0]  rem_ff [0:F];
   logic [F-1:0] quo_ff [0:F];
   logic         one_ff [0:F];

   logic         en;
   logic [15:0]  dd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         single_start_ff <= RESET_SINGLE_START;
         single_end_ff   <= RESET_SINGLE_END;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SINGLE_START: single_start_ff <= csr_wdata;
            CSR_SINGLE_END:   single_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dd       = single_end_ff - single_start_ff;
   assign en       = !vld_ff[F] || !q_full;
   assign req_full = !en;
   assign q_push   = vld_ff[F] && !q_full;
   assign q_data   = one_ff[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo_ff[F]};

   // classify: saturate, zero, or divide
   logic        gt, win, ge_end, one_in;
   logic [15:0] rem_in;
   always_comb begin
      gt     = req_gait_phase > single_start_ff;
      win    = single_end_ff > single_start_ff;
      ge_end = req_gait_phase >= single_end_ff;
      one_in = win ? (gt && ge_end) : gt;
      rem_in = (win && gt && !ge_end) ? (req_gait_phase - single_start_ff) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_push;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         quo_ff[0] <= '0;
         one_ff[0] <= one_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 1; i <= F; i++) begin : g_div
      logic [16:0] r2;
      logic [16:0] diff;
      logic        ge;
      always_comb begin
         r2   = {rem_ff[i-1], 1'b0};
         diff = r2 - {1'b0, dd};
         ge   = (r2 >= {1'b0, dd}) && (dd != 16'd0);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? diff[15:0] : r2[15:0];
            quo_ff[i] <= {quo_ff[i-1][F-2:0], ge};
            one_ff[i] <= one_ff[i-1];
         end
      end
   end

endmodule

[sv/sfp_queue.sv]
module sfp_queue #(
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   import sfp_pkg::*;

   logic [WIDTH-1:0]      mem_ff [0:Q_DEPTH-1];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign full     = count_ff == Q_CNT_BITS'(Q_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_BITS'(Q_DEPTH)) else $error("queue count overflow");
   a_push_only: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("push lost");
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1) else $error("pop lost");

endmodule

[sv/sfp_sinsq.sv]
module sfp_sinsq (
   input  logic        clock,
   input  logic        en,
   input  logic [16:0] u16,
   output logic [16:0] sq
);
   import sfp_pkg::*;

   logic [30:0] u_ff  [1:5];
   logic [30:0] u2_ff [1:5];
   logic [30:0] t_ff  [2:5];
   logic [30:0] sn_ff;
   logic [61:0] sq_ff;

   logic [30:0] u_in;
   logic [61:0] uu;
   logic [61:0] pr [2:5];
   logic [61:0] us;
   logic [62:0] rnd;

   assign u_in = {u16, 14'd0};
   assign uu   = u_in * u_in;

   // stage 1: u and u^2
   always_ff @(posedge clock) begin
      if (en) begin
         u_ff[1]  <= u_in;
         u2_ff[1] <= uu[60:30];
      end
   end

   // Horner steps
   assign pr[2] = u2_ff[1] * SIN_C9;
   assign pr[3] = u2_ff[2] * t_ff[2];
   assign pr[4] = u2_ff[3] * t_ff[3];
   assign pr[5] = u2_ff[4] * t_ff[4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 2; i <= 5; i++) begin
            u_ff[i]  <= u_ff[i-1];
            u2_ff[i] <= u2_ff[i-1];
         end
         t_ff[2] <= SIN_C7 - pr[2][60:30];
         t_ff[3] <= SIN_C5 - pr[3][60:30];
         t_ff[4] <= SIN_C3 - pr[4][60:30];
         t_ff[5] <= SIN_C1 - pr[5][60:30];
      end
   end

   // final multiply by u, capped at one
   assign us = u_ff[5] * t_ff[5];
   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= (us[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : us[60:30];
         sq_ff <= sn_ff * sn_ff;
      end
   end

   // round Q0.60 square to Q0.16
   assign rnd = {1'b0, sq_ff} + (63'd1 << 43);
   assign sq  = rnd[60:44];

endmodule

[sv/sfp_back.sv]
module sfp_back #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [FRACTION_BITS:0] in_s,
   output logic                   in_take,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [15:0]            rsp_support_fraction,
   output logic [15:0]            rsp_forward_fraction,
   output logic [15:0]            rsp_lift_fraction
);
   import sfp_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int DOWN  = (F > 16) ? F - 16 : 0;
   localparam int UP    = (F < 16) ? 16 - F : 0;
   localparam int SW    = (F >= 16) ? F + 1 : 17;
   localparam int WS    = F + 17;
   localparam int PW_N  = 67;
   localparam int KW_I  = 67;
   localparam int SIN_N = 7;
   localparam int NV    = KW_I + SIN_N + 2;
   localparam logic [SW-1:0] LIM =
      (F >= 16) ? SW'(17'h0FFFF) : ((SW'(1) << F) - SW'(1));

   function automatic logic [15:0] sat_port(input logic [SW-1:0] v);
      sat_port = (v > LIM) ? LIM[15:0] : v[15:0];
   endfunction

   logic        vld_ff [0:NV-1];
   pw_type      pw_ff  [0:PW_N-1];
   pw_type      pw_in  [0:PW_N-1];
   logic        en;

   assign en        = !vld_ff[NV-1] || rsp_pop;
   assign in_take   = en && in_valid;
   assign rsp_empty = !vld_ff[NV-1];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NV; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < NV; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 0: Q0.16 view of s and the support port value
   logic [WS-1:0] s_wide;
   always_comb begin
      s_wide        = (WS'(in_s) << UP) >> DOWN;
      pw_in[0]      = '0;
      pw_in[0].s16  = s_wide[16:0];
      pw_in[0].sup  = sat_port(SW'(in_s));
   end

   // stage 1: x^2 and s*(1-s)
   logic [33:0] m1;
   always_comb begin
      m1           = pw_ff[0].s16 * (Q16_ONE - pw_ff[0].s16);
      pw_in[1]     = pw_ff[0];
      pw_in[1].x2  = pw_ff[0].s16[15:0] * pw_ff[0].s16[15:0];
      pw_in[1].m   = 45'(m1);
   end

   // stage 2: x^4 target and skew product
   logic [63:0] x4;
   always_comb begin
      x4           = pw_ff[1].x2 * pw_ff[1].x2;
      pw_in[2]     = pw_ff[1];
      pw_in[2].tgt = {x4, 16'd0};
      pw_in[2].m   = pw_ff[1].m[30:0] * SKEW_COEF;
      pw_in[2].y   = '0;
   end

   // bit search for y with y^5 <= x^4 * 2^16, four stages per bit
   for (genvar n = 3; n < PW_N; n++) begin : g_pw
      localparam int SUB  = (n - 3) % 4;
      localparam int BITP = 15 - (n - 3) / 4;
      logic [15:0] c;
      assign c = pw_ff[n-1].y | (16'd1 << BITP);
      if (SUB == 0) begin : g_sq
         always_comb begin
            pw_in[n]    = pw_ff[n-1];
            pw_in[n].c2 = c * c;
         end
      end else if (SUB == 1) begin : g_qd
         always_comb begin
            pw_in[n]    = pw_ff[n-1];
            pw_in[n].c4 = pw_ff[n-1].c2 * pw_ff[n-1].c2;
         end
      end else if (SUB == 2) begin : g_pp
         always_comb begin
            pw_in[n]     = pw_ff[n-1];
            pw_in[n].phi = pw_ff[n-1].c4[63:32] * c;
            pw_in[n].plo = pw_ff[n-1].c4[31:0] * c;
         end
      end else begin : g_cmp
         logic [79:0] c5;
         always_comb begin
            c5       = {pw_ff[n-1].phi, 32'd0} + {32'd0, pw_ff[n-1].plo};
            pw_in[n] = pw_ff[n-1];
            if (c5 <= pw_ff[n-1].tgt) pw_in[n].y = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < PW_N; i++) pw_ff[i] <= pw_in[i];
      end
   end

   // skewed phase k and folded lift argument w
   logic [16:0] p17, k_in, w_in, k_ff, w_ff;
   logic [45:0] trnd;
   logic [16:0] term;
   logic [17:0] w18;
   logic [15:0] sup_kw_ff;
   always_comb begin
      p17  = pw_ff[PW_N-1].s16[16] ? Q16_ONE : {1'b0, pw_ff[PW_N-1].y};
      trnd = {1'b0, pw_ff[PW_N-1].m} + (46'd1 << 31);
      term = {3'd0, trnd[45:32]};
      k_in = (term > p17) ? 17'd0 : p17 - term;
      w18  = {k_in, 1'b0};
      w_in = (w18 > {1'b0, Q16_ONE}) ? 17'(18'h20000 - w18) : w18[16:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff      <= k_in;
         w_ff      <= w_in;
         sup_kw_ff <= pw_ff[PW_N-1].sup;
      end
   end

   // two sine-squared lanes
   logic [16:0] fwd_sq, lift_sq;
   sfp_sinsq u_fwd (
      .clock (clock),
      .en    (en),
      .u16   (k_ff),
      .sq    (fwd_sq)
   );
   sfp_sinsq u_lift (
      .clock (clock),
      .en    (en),
      .u16   (w_ff),
      .sq    (lift_sq)
   );

   logic [15:0] sup_d_ff [0:SIN_N-1];
   always_ff @(posedge clock) begin
      if (en) begin
         sup_d_ff[0] <= sup_kw_ff;
         for (int i = 1; i < SIN_N; i++) sup_d_ff[i] <= sup_d_ff[i-1];
      end
   end

   // output register, scaled to Q0.F and saturated
   logic [SW-1:0] fwd_sc, lift_sc;
   assign fwd_sc  = (SW'(fwd_sq) << DOWN) >> UP;
   assign lift_sc = (SW'(lift_sq) << DOWN) >> UP;

   logic [15:0] out_sup_ff, out_fwd_ff, out_lift_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         out_sup_ff  <= sup_d_ff[SIN_N-1];
         out_fwd_ff  <= sat_port(fwd_sc);
         out_lift_ff <= sat_port(lift_sc);
      end
   end

   assign rsp_support_fraction = out_sup_ff;
   assign rsp_forward_fraction = out_fwd_ff;
   assign rsp_lift_fraction    = out_lift_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty) else $error("result dropped");
   a_take: assert property (@(posedge clock) disable iff (reset)
      in_take |-> in_valid && en) else $error("take without item");
   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(out_fwd_ff) && $stable(out_lift_ff))
      else $error("result changed while stalled");

endmodule

[bench/tb_top.sv]
module tb_top;
   import sfp_pkg::*;

   localparam int LATENCY = 16 + 78;
   localparam int PHASES  = 8;
   localparam int PER_PHASE = 175;
   // indexes the block ignores
   localparam csr_index_type CSR_SPARE_A = 2'd2;
   localparam csr_index_type CSR_SPARE_B = 2'd3;

   typedef struct {
      logic [15:0] support;
      logic [15:0] forward;
      logic [15:0] lift;
   } profile_type;

   // predicts the swing profile of each accepted phase and checks results in order
   class profile_board;
      logic [15:0] win_start = RESET_SINGLE_START;
      logic [15:0] win_end   = RESET_SINGLE_END;
      profile_type waiting[$];
      int          errors = 0;

      function void set_reg(csr_index_type idx, logic [15:0] val);
         if (idx == CSR_SINGLE_START) win_start = val;
         else if (idx == CSR_SINGLE_END) win_end = val;
      endfunction

      // largest y with y^5 <= s^4 * 2^16
      function longint unsigned pow_08(longint unsigned s16);
         logic [127:0] goal, c, c5;
         longint unsigned y;
         y = 0;
         if (s16 >= 65536) return 65536;
         goal = s16;
         goal = goal * goal;
         goal = (goal * goal) << 16;
         for (int b = 15; b >= 0; b--) begin
            c = y | (64'd1 << b);
            c5 = c * c * c * c * c;
            if (c5 <= goal) y = c[63:0];
         end
         return y;
      endfunction

      // sin^2(pi/2 * u/2^16), Q0.16
      function longint unsigned sin_sq(longint unsigned u16);
         longint unsigned u, u2, t, sn;
         if (u16 > 65536) u16 = 65536;
         u  = u16 << 14;
         u2 = (u * u) >> 30;
         t  = 172273;
         t  = 5026995 - ((u2 * t) >> 30);
         t  = 85569309 - ((u2 * t) >> 30);
         t  = 693598668 - ((u2 * t) >> 30);
         t  = 1686629713 - ((u2 * t) >> 30);
         sn = (u * t) >> 30;
         if (sn > (64'd1 << 30)) sn = 64'd1 << 30;
         return (sn * sn + (64'd1 << 43)) >> 44;
      endfunction

      function logic [15:0] sat16(longint unsigned v);
         return (v > 65535) ? 16'hFFFF : v[15:0];
      endfunction

      function void note(logic [15:0] phase);
         longint unsigned s, p, term, k, w;
         profile_type r;
         if (win_end <= win_start)
            s = (phase > win_start) ? 65536 : 0;
         else if (phase <= win_start)
            s = 0;
         else begin
            s = (longint'(phase - win_start) << 16) / longint'(win_end - win_start);
            if (s > 65536) s = 65536;
         end
         p = pow_08(s);
         term = (11141 * (s * (65536 - s)) + (64'd1 << 31)) >> 32;
         k = (term > p) ? 0 : p - term;
         if (k > 65536) k = 65536;
         w = 2 * k;
         if (w > 65536) w = 131072 - w;
         r.support = sat16(s);
         r.forward = sat16(sin_sq(k));
         r.lift    = sat16(sin_sq(w));
         waiting.push_back(r);
      endfunction

      function void check(logic [15:0] sup, logic [15:0] fwd, logic [15:0] lft);
         profile_type e;
         if (waiting.size() == 0) begin
            $error("unexpected result item %0d %0d %0d", sup, fwd, lft);
            errors++;
            return;
         end
         e = waiting.pop_front();
         if (sup !== e.support) begin
            $error("support_fraction exp %0d got %0d", e.support, sup);
            errors++;
         end
         if (fwd !== e.forward) begin
            $error("forward_fraction exp %0d got %0d", e.forward, fwd);
            errors++;
         end
         if (lft !== e.lift) begin
            $error("lift_fraction exp %0d got %0d", e.lift, lft);
            errors++;
         end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          csr_we = 0;
   csr_index_type csr_index = CSR_SINGLE_START;
   logic [15:0]   csr_wdata = 0;
   logic          req_push = 0;
   logic          req_full;
   logic [15:0]   req_gait_phase = 0;
   logic          rsp_empty;
   logic          rsp_pop = 0;
   logic [15:0]   rsp_support_fraction, rsp_forward_fraction, rsp_lift_fraction;

   profile_board board = new();
   int  pop_gap = 0;
   bit  send_quiet = 0, pop_quiet = 0;

   swing_foot_phase_profile_top i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // result side: sample at rising edge, draw the next stall on each accepted item
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         board.check(rsp_support_fraction, rsp_forward_fraction, rsp_lift_fraction);
         pop_gap = pop_quiet ? 0 : $urandom_range(0, 11);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_pop <= 0;
      else if (pop_gap > 0) begin
         rsp_pop <= 0;
         pop_gap--;
      end else rsp_pop <= 1;
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.set_reg(idx, val);
   endtask

   task automatic push_item(logic [15:0] phase);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(negedge clock);
      end
      req_push       <= 1;
      req_gait_phase <= phase;
      do @(posedge clock); while (req_full);
      board.note(phase);
      @(negedge clock);
   endtask

   // wait until every expected result is back, then let the pipeline settle
   task automatic drain();
      int n;
      n = 0;
      req_push <= 0;
      while (board.waiting.size() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_phase();
      int sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3, 4: return board.win_start + 16'($urandom_range(0, 6)) - 16'd3;
         5, 6, 7: return board.win_end + 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [15:0] a, b;
      repeat (4) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: reset window, then extremes and empty windows
      push_item(16'h0000);
      push_item(16'hFFFF);
      push_item(RESET_SINGLE_START);
      push_item(RESET_SINGLE_START + 16'd1);
      push_item(RESET_SINGLE_END - 16'd1);
      push_item(RESET_SINGLE_END);
      push_item(RESET_SINGLE_END + 16'd1);
      push_item(16'd32768);
      drain();
      write_reg(CSR_SINGLE_START, 16'h0000);
      write_reg(CSR_SINGLE_END, 16'hFFFF);
      write_reg(CSR_SPARE_A, 16'h1234);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      push_item(16'h0000);
      push_item(16'h0001);
      push_item(16'hFFFE);
      push_item(16'hFFFF);
      drain();
      // empty window, equal bounds
      write_reg(CSR_SINGLE_START, 16'd30000);
      write_reg(CSR_SINGLE_END, 16'd30000);
      push_item(16'd29999);
      push_item(16'd30000);
      push_item(16'd30001);
      drain();
      // empty window, end below start
      write_reg(CSR_SINGLE_START, 16'hFFFF);
      write_reg(CSR_SINGLE_END, 16'h0000);
      push_item(16'hFFFF);
      push_item(16'h0000);
      drain();
      // one-step window
      write_reg(CSR_SINGLE_START, 16'hFFFE);
      write_reg(CSR_SINGLE_END, 16'hFFFF);
      push_item(16'hFFFE);
      push_item(16'hFFFF);
      drain();

      // random phases over several windows
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin a = RESET_SINGLE_START; b = RESET_SINGLE_END; end
            1: begin a = 16'h0000; b = 16'hFFFF; end
            2: begin a = 16'h0000; b = 16'h0001; end
            3: begin a = 16'($urandom()); b = a; end
            default: begin a = 16'($urandom()); b = 16'($urandom()); end
         endcase
         write_reg(CSR_SINGLE_START, a);
         write_reg(CSR_SINGLE_END, b);
         send_quiet = (ph % 3 == 1);
         pop_quiet  = (ph % 4 == 2);
         for (int i = 0; i < PER_PHASE; i++) push_item(pick_phase());
         drain();
      end

      if (board.waiting.size() != 0) begin
         $error("%0d result items never arrived", board.waiting.size());
         board.errors++;
      end
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
